/* sv/dtf_pkg.sv */
// ----------------------------------------------------------------------------
// dtf_pkg
// shared widths, register indexes and reset values of the damped trend
// forecaster
// ----------------------------------------------------------------------------
package dtf_pkg;

   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TREND_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HORIZON    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT     = 3'd4;

   localparam logic [16:0] LEVEL_GAIN_RST = 17'd32768;
   localparam logic [16:0] TREND_GAIN_RST = 17'd6554;
   localparam logic [16:0] DAMPING_RST    = 17'd65536;
   localparam logic [3:0]  HORIZON_RST    = 4'd8;
   localparam logic [3:0]  REPORT_RST     = 4'd8;

   localparam int SAMPLE_W = 32;
   localparam int STEP_W   = 3;
   localparam int MSE_W    = 64;

endpackage

/* sv/dtf_req_if.sv */
// ----------------------------------------------------------------------------
// dtf_req_if
// sample channel: valid, ready and one signed sample
// ----------------------------------------------------------------------------
interface dtf_req_if import dtf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* sv/dtf_rsp_if.sv */
// ----------------------------------------------------------------------------
// dtf_rsp_if
// result channel: valid, ready and one forecast step
// ----------------------------------------------------------------------------
interface dtf_rsp_if import dtf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STEP_W-1:0]          step_index;
   logic signed [SAMPLE_W-1:0] forecast;
   logic [MSE_W-1:0]           mean_sq_error;
   logic                       last;

   modport source (output valid, output step_index, output forecast,
                   output mean_sq_error, output last, input ready);
   modport sink   (input valid, input step_index, input forecast,
                   input mean_sq_error, input last, output ready);
endinterface

/* sv/dtf_ram.sv */
// ----------------------------------------------------------------------------
// dtf_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module dtf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/dtf_divider.sv */
// ----------------------------------------------------------------------------
// dtf_divider
// restoring divider, 64 by 32 bits, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dtf_divider import dtf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MSE_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             busy,
   output logic [MSE_W-1:0] quotient
);
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [MSE_W-1:0] quo_ff, quo_in;
   logic [32:0]      trial;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[MSE_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd0;
         rem_in  = 32'd0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[MSE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[MSE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(MSE_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

/* sv/damped_trend_forecaster_top.sv */
// ----------------------------------------------------------------------------
// damped_trend_forecaster_top
// damped trend exponential smoothing with per-step error scoring
// ----------------------------------------------------------------------------
// req_chan takes one signed fixed point sample per transaction; ready is high
// only while the sequencer is idle. rsp_chan then gives as many results as
// the report register asks, clamped to between 1 and the horizon, step 0
// first, last set on the final one. csr_* writes the five registers and is
// to be used only while the block is idle, which the block does not enforce.
// One shared 34 by 34 multiplier and one serial divider do all the work:
// acceptance and the level and trend update (the first two samples set level
// and trend directly), scoring of each scored forecast, then each forecast
// step, with a division for each reported step when errors exist. The next
// sample can be taken in the cycle after the final forecast step. When the
// receiver stalls, the sequencer holds before loading the next result and
// goes on when the output register frees. Reset clears level, trend, error
// sums and counts and sets the registers to their reset values at once; the
// forecast ring is guarded by its fill count and needs no clearing pass.
// ----------------------------------------------------------------------------
module damped_trend_forecaster_top import dtf_pkg::*; #(
   parameter int MAX_HORIZON = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   dtf_req_if.sink                req_chan,
   dtf_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   localparam int IW    = MAX_HORIZON > 1 ? $clog2(MAX_HORIZON) : 1;
   localparam int HW    = $clog2(MAX_HORIZON + 1);
   localparam int NW    = HW > 4 ? HW : 4;
   localparam int DEPTH = MAX_HORIZON * MAX_HORIZON;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int WW    = FRAC_BITS + 1 > 17 ? FRAC_BITS + 1 : 17;
   localparam int CUMW  = FRAC_BITS + HW + 1;

   localparam logic [WW-1:0]        ONE_W   = WW'(1) << FRAC_BITS;
   localparam logic signed [67:0]   HALF    = 68'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [67:0]   MAX32   = 68'sd2147483647;
   localparam logic signed [67:0]   MIN32   = -68'sd2147483648;
   localparam logic [AW-1:0]        MH_A    = AW'(MAX_HORIZON);
   localparam logic [IW-1:0]        LAST_I  = IW'(MAX_HORIZON - 1);
   localparam logic [HW-1:0]        FULL    = HW'(MAX_HORIZON);
   localparam logic [NW-1:0]        MH_N    = NW'(MAX_HORIZON);

   typedef enum logic [4:0] {
      ST_IDLE, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6,
      ST_SC_RD, ST_SC_DAT, ST_SC_ACC, ST_CNT,
      ST_FC_P, ST_FC_C, ST_FC_T, ST_FC_F, ST_FC_DIV, ST_EMIT
   } state_type;

   function automatic logic signed [67:0] rscale(input logic signed [67:0] x);
      return (x + HALF) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > MAX32) return 32'sh7FFFFFFF;
      if (v < MIN32) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [WW-1:0] clamp_w(input logic [16:0] w);
      return (WW'(w) > ONE_W) ? ONE_W : WW'(w);
   endfunction

   state_type               state_ff, state_in;
   logic [16:0]             lgain_ff, lgain_in, tgain_ff, tgain_in, damp_ff, damp_in;
   logic [3:0]              horiz_ff, horiz_in, report_ff, report_in;
   logic signed [31:0]      level_ff, level_in, trend_ff, trend_in, pl_ff, pl_in;
   logic signed [31:0]      y_ff, y_in, f_ff, f_in;
   logic signed [33:0]      damped_ff, damped_in;
   logic signed [67:0]      acc_ff, acc_in, prod_ff, prod_in;
   logic [1:0]              seen_ff, seen_in;
   logic [MSE_W-1:0]        sums_ff [MAX_HORIZON];
   logic [MSE_W-1:0]        sums_in [MAX_HORIZON];
   logic [31:0]             count_ff, count_in;
   logic [HW-1:0]           fill_ff, fill_in, i_ff, i_in;
   logic [IW-1:0]           head_ff, head_in;
   logic [FRAC_BITS:0]      p_ff, p_in;
   logic [CUMW-1:0]         cum_ff, cum_in;
   logic                    zero_ff, zero_in;
   logic                    out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [STEP_W-1:0]       out_step_ff, out_step_in;
   logic signed [31:0]      out_fc_ff, out_fc_in;
   logic [MSE_W-1:0]        out_mse_ff, out_mse_in;

   logic signed [33:0]      mul_a, mul_b;
   logic [WW-1:0]           a_w, b_w, phi_w;
   logic [NW-1:0]           h_n, r_n, n_score, i_n;
   logic [IW-1:0]           i_idx;
   logic [IW:0]             slot_w;
   logic [AW-1:0]           ram_raddr, ram_waddr;
   logic                    ram_we;
   logic signed [31:0]      ram_rdata;
   logic signed [32:0]      diff;
   logic [32:0]             mag;
   logic [MSE_W:0]          sum_w;
   logic signed [32:0]      mean;
   logic signed [67:0]      scaled;
   logic [HW+2:0]           i_ext;
   logic                    div_start, div_busy;
   logic [MSE_W-1:0]        div_q;

   dtf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (f_in),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dtf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_ff[i_idx]),
      .divisor  (count_ff - 32'(i_ff)),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      a_w   = clamp_w(lgain_ff);
      b_w   = clamp_w(tgain_ff);
      phi_w = clamp_w(damp_ff);
      h_n   = (horiz_ff == 4'd0) ? NW'(1) :
              (NW'(horiz_ff) > MH_N) ? MH_N : NW'(horiz_ff);
      r_n   = (report_ff == 4'd0) ? NW'(1) :
              (NW'(report_ff) > h_n) ? h_n : NW'(report_ff);
      n_score = (h_n < NW'(fill_ff)) ? h_n : NW'(fill_ff);
      i_n   = NW'(i_ff);
      i_idx = i_ff[IW-1:0];
      i_ext = (HW+3)'(i_ff);
      if (head_ff >= i_idx) begin
         slot_w = {1'b0, head_ff} - {1'b0, i_idx};
      end else begin
         slot_w = {1'b0, head_ff} + (IW+1)'(MAX_HORIZON) - {1'b0, i_idx};
      end
      ram_raddr = AW'(slot_w[IW-1:0]) * MH_A + AW'(i_idx);
      ram_waddr = AW'(head_ff) * MH_A + AW'(i_idx);
      diff   = 33'(y_ff) - 33'(ram_rdata);
      mag    = diff[32] ? 33'(-diff) : 33'(diff);
      sum_w  = {1'b0, sums_ff[i_idx]} + {1'b0, prod_ff[MSE_W-1:0]};
      mean   = (33'(req_chan.sample) + 33'(level_ff)) >>> 1;
      scaled = rscale(prod_ff);

      state_in   = state_ff;
      lgain_in   = lgain_ff;
      tgain_in   = tgain_ff;
      damp_in    = damp_ff;
      horiz_in   = horiz_ff;
      report_in  = report_ff;
      level_in   = level_ff;
      trend_in   = trend_ff;
      pl_in      = pl_ff;
      y_in       = y_ff;
      f_in       = f_ff;
      damped_in  = damped_ff;
      acc_in     = acc_ff;
      seen_in    = seen_ff;
      sums_in    = sums_ff;
      count_in   = count_ff;
      fill_in    = fill_ff;
      i_in       = i_ff;
      head_in    = head_ff;
      p_in       = p_ff;
      cum_in     = cum_ff;
      zero_in    = zero_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_step_in  = out_step_ff;
      out_fc_in    = out_fc_ff;
      out_mse_in   = out_mse_ff;
      mul_a      = 34'sd0;
      mul_b      = 34'sd0;
      ram_we     = 1'b0;
      div_start  = 1'b0;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_LEVEL_GAIN: lgain_in  = csr_wdata;
            CSR_TREND_GAIN: tgain_in  = csr_wdata;
            CSR_DAMPING:    damp_in   = csr_wdata;
            CSR_HORIZON:    horiz_in  = csr_wdata[3:0];
            CSR_REPORT:     report_in = csr_wdata[3:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            if (req_chan.valid) begin
               y_in = req_chan.sample;
               case (seen_ff)
                  2'd0: begin
                     level_in = req_chan.sample;
                     trend_in = 32'sd0;
                     seen_in  = 2'd1;
                     state_in = ST_SC_RD;
                  end
                  2'd1: begin
                     level_in = mean[31:0];
                     trend_in = sat32(68'(33'(req_chan.sample) - mean));
                     seen_in  = 2'd2;
                     state_in = ST_SC_RD;
                  end
                  default: state_in = ST_U1;
               endcase
            end
         end
         ST_U1: begin
            mul_a = 34'($signed({1'b0, phi_w}));
            mul_b = 34'(trend_ff);
            state_in = ST_U2;
         end
         ST_U2: begin
            damped_in = scaled[33:0];
            mul_a = 34'($signed({1'b0, a_w}));
            mul_b = 34'(y_ff);
            state_in = ST_U3;
         end
         ST_U3: begin
            acc_in = prod_ff;
            mul_a = 34'($signed({1'b0, ONE_W - a_w}));
            mul_b = 34'(level_ff) + damped_ff;
            state_in = ST_U4;
         end
         ST_U4: begin
            pl_in    = level_ff;
            level_in = sat32(rscale(acc_ff + prod_ff));
            mul_a = 34'($signed({1'b0, ONE_W - b_w}));
            mul_b = damped_ff;
            state_in = ST_U5;
         end
         ST_U5: begin
            acc_in = prod_ff;
            mul_a = 34'($signed({1'b0, b_w}));
            mul_b = 34'(level_ff) - 34'(pl_ff);
            state_in = ST_U6;
         end
         ST_U6: begin
            trend_in = sat32(rscale(acc_ff + prod_ff));
            state_in = ST_SC_RD;
         end
         ST_SC_RD: begin
            if (i_n < n_score) begin
               state_in = ST_SC_DAT;
            end else begin
               state_in = ST_CNT;
            end
         end
         ST_SC_DAT: begin
            mul_a = 34'($signed({1'b0, mag}));
            mul_b = 34'($signed({1'b0, mag}));
            state_in = ST_SC_ACC;
         end
         ST_SC_ACC: begin
            sums_in[i_idx] = sum_w[MSE_W] ? '1 : sum_w[MSE_W-1:0];
            i_in = i_ff + HW'(1);
            state_in = ST_SC_RD;
         end
         ST_CNT: begin
            if (fill_ff != '0 && count_ff != 32'hFFFFFFFF) begin
               count_in = count_ff + 32'd1;
            end
            head_in  = (head_ff == LAST_I) ? '0 : head_ff + IW'(1);
            i_in     = '0;
            p_in     = ONE_W[FRAC_BITS:0];
            cum_in   = '0;
            state_in = ST_FC_P;
         end
         ST_FC_P: begin
            mul_a = 34'($signed({1'b0, p_ff}));
            mul_b = 34'($signed({1'b0, phi_w}));
            state_in = ST_FC_C;
         end
         ST_FC_C: begin
            p_in   = scaled[FRAC_BITS:0];
            cum_in = cum_ff + CUMW'(scaled[FRAC_BITS:0]);
            state_in = ST_FC_T;
         end
         ST_FC_T: begin
            mul_a = 34'(trend_ff);
            mul_b = 34'($signed({1'b0, cum_ff}));
            state_in = ST_FC_F;
         end
         ST_FC_F: begin
            f_in   = sat32(68'(level_ff) + scaled);
            ram_we = 1'b1;
            if (i_n < r_n) begin
               zero_in = !(count_ff > 32'(i_ff));
               div_start = count_ff > 32'(i_ff);
               state_in = ST_FC_DIV;
            end else if (i_idx == LAST_I) begin
               fill_in  = (fill_ff == FULL) ? fill_ff : fill_ff + HW'(1);
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + HW'(1);
               state_in = ST_FC_P;
            end
         end
         ST_FC_DIV: begin
            if (!div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_step_in  = i_ext[STEP_W-1:0];
               out_fc_in    = f_ff;
               out_mse_in   = zero_ff ? '0 : div_q;
               out_last_in  = (i_n + NW'(1)) == r_n;
               if (i_idx == LAST_I) begin
                  fill_in  = (fill_ff == FULL) ? fill_ff : fill_ff + HW'(1);
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + HW'(1);
                  state_in = ST_FC_P;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lgain_ff     <= LEVEL_GAIN_RST;
         tgain_ff     <= TREND_GAIN_RST;
         damp_ff      <= DAMPING_RST;
         horiz_ff     <= HORIZON_RST;
         report_ff    <= REPORT_RST;
         level_ff     <= 32'sd0;
         trend_ff     <= 32'sd0;
         seen_ff      <= 2'd0;
         count_ff     <= 32'd0;
         fill_ff      <= '0;
         head_ff      <= '0;
         i_ff         <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_HORIZON; k++) begin
            sums_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         lgain_ff     <= lgain_in;
         tgain_ff     <= tgain_in;
         damp_ff      <= damp_in;
         horiz_ff     <= horiz_in;
         report_ff    <= report_in;
         level_ff     <= level_in;
         trend_ff     <= trend_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         i_ff         <= i_in;
         out_valid_ff <= out_valid_in;
         sums_ff      <= sums_in;
      end
      pl_ff       <= pl_in;
      y_ff        <= y_in;
      f_ff        <= f_in;
      damped_ff   <= damped_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      p_ff        <= p_in;
      cum_ff      <= cum_in;
      zero_ff     <= zero_in;
      out_last_ff <= out_last_in;
      out_step_ff <= out_step_in;
      out_fc_ff   <= out_fc_in;
      out_mse_ff  <= out_mse_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.step_index    = out_step_ff;
   assign rsp_chan.forecast      = out_fc_ff;
   assign rsp_chan.mean_sq_error = out_mse_ff;
   assign rsp_chan.last          = out_last_ff;
endmodule
